// ===== rtl/ebcs_pkg.sv =====
// Package for the emergency brake check sequencer: types, codes and reset values.
// Used by ebcs_cfg, ebcs_core and emergency_brake_check_sequencer_top.
`default_nettype none

package ebcs_pkg;

  localparam int TIME_BITS = 32;
  localparam int LEVEL_W = 16;
  localparam int NUM_REGS = 5;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [3:0] {
    ST_CHECK_ASMS       = 4'd0,
    ST_CHECK_PRESSURE   = 4'd1,
    ST_BUTTON_HOLD      = 4'd2,
    ST_PRESSURE_LOW     = 4'd3,
    ST_PRESSURE_HIGH    = 4'd4,
    ST_CTRL_ACK         = 4'd5,
    ST_IDLE             = 4'd6,
    ST_PRECHARGE_PRESS  = 4'd7,
    ST_CHECK_TS         = 4'd8,
    ST_CHECK_COMPUTE    = 4'd9,
    ST_READY            = 4'd10,
    ST_RELEASE_BRAKE    = 4'd11,
    ST_DRIVE            = 4'd12,
    ST_BRAKING          = 4'd13,
    ST_SHUTDOWN         = 4'd14
  } mode_t;

  // peer controller codes
  localparam logic [1:0] CTRL_IDLE      = 2'd1;
  localparam logic [1:0] CTRL_PRECHARGE = 2'd2;
  localparam logic [1:0] CTRL_RTD       = 2'd3;
  localparam logic [1:0] DVL_CHECK      = 2'd1;
  localparam logic [1:0] DVL_RELEASE    = 2'd2;
  localparam logic [1:0] DVL_ACTIVATE   = 2'd3;

  // register indexes (byte address is 4x)
  localparam logic [2:0] REG_PRESSURE_HIGH = 3'd0;
  localparam logic [2:0] REG_PRESSURE_LOW  = 3'd1;
  localparam logic [2:0] REG_LED_TOGGLE    = 3'd2;
  localparam logic [2:0] REG_BUTTON_HOLD   = 3'd3;
  localparam logic [2:0] REG_RELEASE_HOLD  = 3'd4;

  localparam level_t RST_PRESSURE_HIGH = 16'd1000;
  localparam level_t RST_PRESSURE_LOW  = 16'd200;
  localparam level_t RST_LED_TOGGLE    = 16'd500;
  localparam level_t RST_BUTTON_HOLD   = 16'd1000;
  localparam level_t RST_RELEASE_HOLD  = 16'd2000;

  typedef struct packed {
    level_t pressure_high_level;
    level_t pressure_low_level;
    level_t led_toggle_ms;
    level_t button_hold_ms;
    level_t release_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        asms_ok;
    logic        brake_valid;
    level_t      brake_front;
    level_t      brake_rear;
    logic        shutdown_seen;
    logic        shutdown_ok;
    logic        button_pressed;
    logic [1:0]  ctrl_peer_state;
    logic [1:0]  dvl_peer_state;
  } item_t;

  typedef struct packed {
    logic [3:0] state_code;
    logic       ebs_release;
    logic       shutdown_line;
    logic       board_power;
    logic       button_led;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/ebcs_cfg.sv =====
// APB register file for the sequencer thresholds and timer settings.
// Depends on ebcs_pkg.
`default_nettype none

module ebcs_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ebcs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ebcs_pkg::DATA_W-1:0] pwdata,
  output logic      [ebcs_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output ebcs_pkg::cfg_t                   cfg
);
  import ebcs_pkg::*;

  logic       wr_en;
  logic [2:0] idx;
  level_t     wval;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign wval   = pwdata[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressure_high_level <= RST_PRESSURE_HIGH;
      cfg.pressure_low_level  <= RST_PRESSURE_LOW;
      cfg.led_toggle_ms       <= RST_LED_TOGGLE;
      cfg.button_hold_ms      <= RST_BUTTON_HOLD;
      cfg.release_hold_ms     <= RST_RELEASE_HOLD;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRESSURE_HIGH: cfg.pressure_high_level <= wval;
        REG_PRESSURE_LOW:  cfg.pressure_low_level  <= wval;
        REG_LED_TOGGLE:    cfg.led_toggle_ms       <= wval;
        REG_BUTTON_HOLD:   cfg.button_hold_ms      <= wval;
        REG_RELEASE_HOLD:  cfg.release_hold_ms     <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PRESSURE_HIGH: prdata = DATA_W'(cfg.pressure_high_level);
      REG_PRESSURE_LOW:  prdata = DATA_W'(cfg.pressure_low_level);
      REG_LED_TOGGLE:    prdata = DATA_W'(cfg.led_toggle_ms);
      REG_BUTTON_HOLD:   prdata = DATA_W'(cfg.button_hold_ms);
      REG_RELEASE_HOLD:  prdata = DATA_W'(cfg.release_hold_ms);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ebcs_core.sv =====
// Sequencer state, timers and result register; one request per cycle unless a result waits and out_ready is low.
// Depends on ebcs_pkg.
`default_nettype none

module ebcs_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ebcs_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ebcs_pkg::item_t item,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ebcs_pkg::result_t    result
);
  import ebcs_pkg::*;

  mode_t  mode, mode_next;
  level_t front_level, rear_level, front_next, rear_next;
  time_t  blink_start, blink_start_next;
  time_t  hold_start, hold_start_next;
  time_t  low_start, low_start_next;
  logic   hold_valid, hold_valid_next;
  logic   low_valid, low_valid_next;
  logic   lamp_on, lamp_on_next;
  logic   release_on, release_on_next;

  logic   accept;
  time_t  now, blink_el, hold_el, low_el;
  logic   active, sd_trip, watches, asms_drop;
  logic   blink_due, hold_done, both_low, low_done;
  logic   front_high, both_high;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  assign now        = item.now_ms[TIME_BITS-1:0];
  assign front_next = item.brake_valid ? item.brake_front : front_level;
  assign rear_next  = item.brake_valid ? item.brake_rear  : rear_level;

  // wrapping elapsed times
  assign blink_el = now - blink_start;
  assign hold_el  = now - hold_start;
  assign low_el   = now - low_start;

  assign active    = (mode <= ST_BRAKING);
  assign sd_trip   = item.shutdown_seen & ~item.shutdown_ok & (mode != ST_BRAKING);
  assign watches   = (mode == ST_CHECK_PRESSURE) || (mode >= ST_CTRL_ACK);
  assign asms_drop = watches & ~item.asms_ok;

  assign blink_due  = blink_el > TIME_BITS'(cfg.led_toggle_ms);
  assign hold_done  = item.button_pressed & hold_valid
                      & (hold_el > TIME_BITS'(cfg.button_hold_ms));
  assign both_low   = (front_next < cfg.pressure_low_level)
                      & (rear_next < cfg.pressure_low_level);
  assign low_done   = both_low & low_valid & (low_el > TIME_BITS'(cfg.release_hold_ms));
  assign front_high = front_next > cfg.pressure_high_level;
  assign both_high  = front_high & (rear_next > cfg.pressure_high_level);

  // next state
  always_comb begin
    mode_next = mode;
    if (!active) begin
      mode_next = mode;
    end else if (sd_trip) begin
      mode_next = ST_SHUTDOWN;
    end else if (asms_drop) begin
      mode_next = ST_CHECK_ASMS;
    end else begin
      unique case (mode)
        ST_CHECK_ASMS:      if (item.asms_ok) mode_next = ST_CHECK_PRESSURE;
        ST_CHECK_PRESSURE:  if (front_high) mode_next = ST_BUTTON_HOLD;
        ST_BUTTON_HOLD:     if (hold_done) mode_next = ST_PRESSURE_LOW;
        ST_PRESSURE_LOW:    if (low_done) mode_next = ST_PRESSURE_HIGH;
        ST_PRESSURE_HIGH:   if (both_high) mode_next = ST_CTRL_ACK;
        ST_CTRL_ACK:        if (item.ctrl_peer_state == CTRL_IDLE) mode_next = ST_IDLE;
        ST_IDLE:            if (item.button_pressed) mode_next = ST_PRECHARGE_PRESS;
        ST_PRECHARGE_PRESS: begin
          if (!item.button_pressed) mode_next = ST_IDLE;
          else if (item.ctrl_peer_state == CTRL_PRECHARGE) mode_next = ST_CHECK_TS;
        end
        ST_CHECK_TS: begin
          if (item.ctrl_peer_state == CTRL_IDLE) mode_next = ST_IDLE;
          else if (item.ctrl_peer_state == CTRL_RTD) mode_next = ST_CHECK_COMPUTE;
        end
        ST_CHECK_COMPUTE:   if (item.dvl_peer_state == DVL_CHECK) mode_next = ST_READY;
        ST_READY:           if (item.dvl_peer_state == DVL_RELEASE) mode_next = ST_RELEASE_BRAKE;
        ST_RELEASE_BRAKE:   if (front_next < cfg.pressure_low_level) mode_next = ST_DRIVE;
        ST_DRIVE:           if (item.dvl_peer_state == DVL_ACTIVATE) mode_next = ST_BRAKING;
        default: ;
      endcase
    end
  end

  // lamp, brake release and timer marks
  always_comb begin
    lamp_on_next     = lamp_on;
    release_on_next  = release_on;
    blink_start_next = blink_start;
    hold_start_next  = hold_start;
    hold_valid_next  = hold_valid;
    low_start_next   = low_start;
    low_valid_next   = low_valid;
    if (active) begin
      if (sd_trip) begin
        if (mode == ST_BUTTON_HOLD || mode == ST_IDLE) lamp_on_next = 1'b0;
      end else begin
        // lamp follows idle/precharge even when the switch drops this pass
        if (mode == ST_IDLE) lamp_on_next = 1'b1;
        else if (mode == ST_PRECHARGE_PRESS) lamp_on_next = 1'b0;
        if (asms_drop) begin
          release_on_next = 1'b0;
        end else begin
          unique case (mode)
            ST_CHECK_PRESSURE: begin
              if (front_high) begin
                hold_valid_next  = 1'b0;
                blink_start_next = now;
                lamp_on_next     = 1'b1;
              end
            end
            ST_BUTTON_HOLD: begin
              if (blink_due) begin
                lamp_on_next     = ~lamp_on;
                blink_start_next = now;
              end
              if (!item.button_pressed) begin
                hold_valid_next = 1'b0;
              end else if (!hold_valid) begin
                hold_start_next = now;
                hold_valid_next = 1'b1;
              end else if (hold_done) begin
                lamp_on_next    = 1'b0;
                release_on_next = 1'b1;
                low_start_next  = now;
                low_valid_next  = 1'b1;
              end
            end
            ST_PRESSURE_LOW: begin
              if (!both_low) begin
                low_valid_next = 1'b0;
              end else if (!low_valid) begin
                low_start_next = now;
                low_valid_next = 1'b1;
              end else if (low_done) begin
                release_on_next = 1'b0;
              end
            end
            ST_READY:
              if (item.dvl_peer_state == DVL_RELEASE) release_on_next = 1'b1;
            ST_DRIVE:
              if (item.dvl_peer_state == DVL_ACTIVATE) release_on_next = 1'b0;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= ST_CHECK_ASMS;
      front_level <= '0;
      rear_level  <= '0;
      blink_start <= '0;
      hold_start  <= '0;
      hold_valid  <= 1'b0;
      low_start   <= '0;
      low_valid   <= 1'b0;
      lamp_on     <= 1'b0;
      release_on  <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      front_level <= front_next;
      rear_level  <= rear_next;
      blink_start <= blink_start_next;
      hold_start  <= hold_start_next;
      hold_valid  <= hold_valid_next;
      low_start   <= low_start_next;
      low_valid   <= low_valid_next;
      lamp_on     <= lamp_on_next;
      release_on  <= release_on_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.state_code    <= mode_next;
      result.ebs_release   <= release_on_next;
      result.shutdown_line <= 1'b1;
      result.board_power   <= 1'b1;
      result.button_led    <= lamp_on_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/emergency_brake_check_sequencer_top.sv =====
// Top level of the emergency brake check sequencer: stream ports and APB port.
// Depends on ebcs_pkg, ebcs_cfg and ebcs_core.
`default_nettype none

// One request is one control pass and yields one result, registered on
// acceptance. A request can be taken every cycle: the sequencer state and
// timers are registered on acceptance too, and s_tready only drops while an
// unread result sits in the output register and m_tready is low. Write the APB
// registers only while no request is in flight.
module emergency_brake_check_sequencer_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // slave side
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // tdata: now_ms[31:0], asms_ok[32], brake_front[48:33], brake_rear[64:49],
  // shutdown_ok[65], button_pressed[66], ctrl_peer_state[68:67],
  // dvl_peer_state[70:69], zero[71]
  input  wire logic [ebcs_pkg::S_TDATA_W-1:0] s_tdata,
  // tuser: brake_valid[0], shutdown_seen[1]
  input  wire logic [ebcs_pkg::S_TUSER_W-1:0] s_tuser,
  // master side
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // tdata: state_code[3:0], ebs_release[4], shutdown_line[5], board_power[6],
  // button_led[7]
  output logic      [ebcs_pkg::M_TDATA_W-1:0] m_tdata,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ebcs_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [ebcs_pkg::DATA_W-1:0]    pwdata,
  output logic      [ebcs_pkg::DATA_W-1:0]    prdata,
  output logic                                pready
);
  import ebcs_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t result;

  assign item.now_ms          = s_tdata[31:0];
  assign item.asms_ok         = s_tdata[32];
  assign item.brake_front     = s_tdata[48:33];
  assign item.brake_rear      = s_tdata[64:49];
  assign item.shutdown_ok     = s_tdata[65];
  assign item.button_pressed  = s_tdata[66];
  assign item.ctrl_peer_state = s_tdata[68:67];
  assign item.dvl_peer_state  = s_tdata[70:69];
  assign item.brake_valid     = s_tuser[0];
  assign item.shutdown_seen   = s_tuser[1];

  assign m_tdata = {result.button_led, result.board_power, result.shutdown_line,
                    result.ebs_release, result.state_code};

  ebcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ebcs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

endmodule

`default_nettype wire
